// ===== hdl/bbe_pkg.sv =====
// Shared types, constants and reciprocal table for the edge-aware 3x3 box blur.
`timescale 1ns / 1ps
package bbe_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  localparam int LANES = 3;  // red, green, blue
  localparam int TAPS  = 9;  // 3x3 window

  localparam int SUM_W   = 12;  // 9 * 255 fits
  localparam int NUMER_W = 13;  // 2*sum + count
  localparam int RECIP_W = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W  = NUMER_W + RECIP_W;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] pixel_t;
  typedef logic [3:0]  count_t;

  // Register map, word index
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Input item kind
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // ceil(2^18 / (2*count)); count 0 is treated as 1, codes above 9 never occur
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    18'd131072, 18'd131072, 18'd65536, 18'd43691,
    18'd32768,  18'd26215,  18'd21846, 18'd18725,
    18'd16384,  18'd14564,  18'd131072, 18'd131072,
    18'd131072, 18'd131072, 18'd131072, 18'd131072
  };

  // Per-lane control from the window stage
  typedef struct packed {
    logic            ld;
    logic [TAPS-1:0] mask;
  } lane_ctl_t;

endpackage

// ===== hdl/bbe_in_if.sv =====
// Input channel: one pixel or drain tick per item.
`timescale 1ns / 1ps
interface bbe_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, operation, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, operation, in_red, in_green, in_blue, output ready);
endinterface

// ===== hdl/bbe_out_if.sv =====
// Output channel: one blurred pixel per item.
`timescale 1ns / 1ps
interface bbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ===== hdl/box_blur_3x3_edge_aware.sv =====
// Top level of the edge-aware 3x3 box blur: counters, window, line stores and lanes.
//
//  channel   | role   | handshake             | payload
//  ----------+--------+-----------------------+------------------------------------------
//  pixels    | sink   | valid/ready           | operation, in_red, in_green, in_blue
//  blurred   | source | valid/ready           | out_red, out_green, out_blue, frame_last
//  APB       | slave  | psel/penable, pready=1| image_width @0x0, image_height @0x4
//
//  One item per clock sustained while the output is not stalled. A result passes
//  the lane sum stage register, then the reciprocal multiply into the output register.
//  The line-store read for the next column is issued as the current item is
//  taken, so the registered RAM read does not hold up the next item.
//  Reset is synchronous; the line stores are not cleared and need no sweep.
//  pixels.ready falls only when both the sum stage and the output register hold
//  results and the output is stalled.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = bbe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbe_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  bbe_in_if.sink      pixels,
  bbe_out_if.source   blurred,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bbe_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column index / line-store address
  localparam int WW = $clog2(MAX_WIDTH + 1);   // frame width
  localparam int RW = $clog2(MAX_HEIGHT);      // row index
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // frame height
  localparam int W_RST = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;
  localparam int H_RST = (HEIGHT_RESET < MAX_HEIGHT) ? HEIGHT_RESET : MAX_HEIGHT;

  // ---------------- configuration ----------------
  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  logic [10:0]   wr_width;
  logic [12:0]   wr_height;
  logic [WW-1:0] img_w;
  logic [HW-1:0] img_h;
  logic [WW-1:0] img_w_next;
  logic [HW-1:0] img_h_next;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[2]);
  assign wr_width  = pwdata[10:0];
  assign wr_height = pwdata[12:0];

  // zero reads as one, oversize saturates
  always_comb begin
    if (wr_width == '0) begin
      img_w_next = WW'(1);
    end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
      img_w_next = WW'(MAX_WIDTH);
    end else begin
      img_w_next = WW'(wr_width);
    end
    if (wr_height == '0) begin
      img_h_next = HW'(1);
    end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
      img_h_next = HW'(MAX_HEIGHT);
    end else begin
      img_h_next = HW'(wr_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= WW'(W_RST);
      img_h <= HW'(H_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  img_w <= img_w_next;
        REG_HEIGHT: img_h <= img_h_next;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = 32'(img_w);
      REG_HEIGHT: prdata = 32'(img_h);
      default:    prdata = '0;
    endcase
  end

  // ---------------- handshake and pipeline control ----------------
  logic fire;
  logic rdy;
  logic s1_v;
  logic out_v;
  logic s2_free;
  logic ld;

  assign s2_free = !out_v || blurred.ready;
  assign rdy     = !s1_v || s2_free;
  assign fire    = pixels.valid && rdy;
  assign pixels.ready = rdy;

  // ---------------- position counters ----------------
  // ar_sat counts arrival rows up to two; only "row 0", "row 1", "later" matter.
  logic [CW-1:0] ac, ac_next;
  logic [1:0]    ar_sat, ar_sat_next;
  logic [CW-1:0] ec, ec_next;
  logic [RW-1:0] er, er_next;
  logic [WW-1:0] ac_inc, ec_inc;
  logic [HW-1:0] er_inc;
  logic          a_wrap;
  logic          emitting;
  logic          ec_first, ec_last, er_first, er_last;
  logic          frame_end;
  logic          restart;

  assign ac_inc   = WW'(ac) + WW'(1);
  assign a_wrap   = ac_inc >= img_w;
  assign ec_inc   = WW'(ec) + WW'(1);
  assign er_inc   = HW'(er) + HW'(1);
  assign ec_first = (ec == '0);
  assign ec_last  = ec_inc >= img_w;
  assign er_first = (er == '0);
  assign er_last  = er_inc >= img_h;
  assign emitting = (ar_sat == 2'd2) || (ar_sat == 2'd1 && ac != '0);
  assign frame_end = er_last && ec_last;
  assign ld       = fire && emitting;
  assign restart  = cfg_wr || (ld && frame_end);

  always_comb begin
    ac_next     = ac;
    ar_sat_next = ar_sat;
    ec_next     = ec;
    er_next     = er;
    if (fire) begin
      if (a_wrap) begin
        ac_next = '0;
        if (ar_sat != 2'd2) begin
          ar_sat_next = ar_sat + 2'd1;
        end
      end else begin
        ac_next = ac_inc[CW-1:0];
      end
      if (emitting) begin
        if (ec_last) begin
          ec_next = '0;
          er_next = er_inc[RW-1:0];
        end else begin
          ec_next = ec_inc[CW-1:0];
        end
      end
    end
    if (restart || rst) begin
      ac_next     = '0;
      ar_sat_next = '0;
      ec_next     = '0;
      er_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ac     <= '0;
      ar_sat <= '0;
      ec     <= '0;
      er     <= '0;
    end else begin
      ac     <= ac_next;
      ar_sat <= ar_sat_next;
      ec     <= ec_next;
      er     <= er_next;
    end
  end

  // ---------------- line stores ----------------
  // Read is issued for the column of the next item; if that column is the one
  // just written (one-pixel-wide frame, or restart at column zero) the written
  // data is forwarded through the bypass registers instead.
  pixel_t pix;
  pixel_t up_rd, mid_rd;
  pixel_t fresh [3];
  logic   byp;
  pixel_t byp_up, byp_mid;

  assign pix = (op_t'(pixels.operation) == OP_PIXEL) ?
               {pixels.in_red, pixels.in_green, pixels.in_blue} : '0;

  assign fresh[0] = byp ? byp_up  : up_rd;
  assign fresh[1] = byp ? byp_mid : mid_rd;
  assign fresh[2] = pix;

  bbe_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (fire),
    .waddr (ac),
    .wdata (fresh[1]),
    .raddr (ac_next),
    .rdata (up_rd)
  );

  bbe_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (fire),
    .waddr (ac),
    .wdata (pix),
    .raddr (ac_next),
    .rdata (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= fire && (ac_next == ac);
    end
    byp_up  <= fresh[1];
    byp_mid <= pix;
  end

  // ---------------- window ----------------
  // wc[0..2]: left column (top, middle, bottom), wc[3..5]: centre column
  pixel_t wc [6];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < 6; i++) begin
        wc[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < 3; i++) begin
        wc[i]   <= wc[i+3];
        wc[i+3] <= fresh[i];
      end
    end
  end

  pixel_t    win [TAPS];
  logic [2:0] col_ok, row_ok;
  lane_ctl_t lane_ctl;
  logic [1:0] ncols, nrows;
  count_t    count_d;

  assign col_ok = {!ec_last, 1'b1, !ec_first};
  assign row_ok = {!er_last, 1'b1, !er_first};
  assign ncols  = 2'd3 - 2'(ec_first) - 2'(ec_last);
  assign nrows  = 2'd3 - 2'(er_first) - 2'(er_last);
  assign count_d = count_t'(ncols) * count_t'(nrows);

  always_comb begin
    lane_ctl.ld = ld;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        lane_ctl.mask[c*3+r] = col_ok[c] & row_ok[r];
      end
    end
    for (int r = 0; r < 3; r++) begin
      win[r]   = wc[r];
      win[3+r] = wc[3+r];
      win[6+r] = fresh[r];
    end
  end

  // ---------------- sum stage bookkeeping ----------------
  count_t cnt;
  logic   s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (ld) begin
      s1_v <= 1'b1;
    end else if (s2_free) begin
      s1_v <= 1'b0;
    end
    if (ld) begin
      cnt     <= count_d;
      s1_last <= frame_end;
    end
  end

  // ---------------- colour lanes ----------------
  chan_t means [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    chan_t taps [TAPS];

    always_comb begin
      for (int k = 0; k < TAPS; k++) begin
        taps[k] = win[k][8*(LANES-1-l) +: 8];
      end
    end

    bbe_lane u_lane (
      .clk   (clk),
      .taps  (taps),
      .ctl   (lane_ctl),
      .count (cnt),
      .mean  (means[l])
    );
  end

  // ---------------- merge into output register ----------------
  chan_t o_red, o_green, o_blue;
  logic  o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s2_free) begin
      out_v <= s1_v;
    end
    if (s2_free && s1_v) begin
      o_red   <= means[0];
      o_green <= means[1];
      o_blue  <= means[2];
      o_last  <= s1_last;
    end
  end

  assign blurred.valid      = out_v;
  assign blurred.out_red    = o_red;
  assign blurred.out_green  = o_green;
  assign blurred.out_blue   = o_blue;
  assign blurred.frame_last = o_last;

`ifndef SYNTH
  a_ac_in_row: assert property (@(posedge clk) disable iff (rst)
    WW'(ac) < img_w)
    else $error("arrival column outside frame width");

  a_ec_in_row: assert property (@(posedge clk) disable iff (rst)
    WW'(ec) < img_w)
    else $error("emit column outside frame width");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (ld && frame_end) |=> (ac == '0 && ec == '0 && er == '0 && ar_sat == '0))
    else $error("counters not cleared after last pixel of frame");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !s2_free) |=> s1_v)
    else $error("sum stage dropped an item while output stalled");
`endif
endmodule

// ===== hdl/bbe_ram.sv =====
// Generic single-write, single-read RAM with registered read (old data on collision).
`timescale 1ns / 1ps
module bbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/bbe_lane.sv =====
// One colour lane: masked window sum, then rounded mean via reciprocal multiply.
`timescale 1ns / 1ps
module bbe_lane (
  input  logic              clk,
  input  bbe_pkg::chan_t    taps [bbe_pkg::TAPS],
  input  bbe_pkg::lane_ctl_t ctl,
  input  bbe_pkg::count_t   count,
  output bbe_pkg::chan_t    mean
);
  import bbe_pkg::*;

  logic [SUM_W-1:0]   col_sum [3];
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_q;
  logic [NUMER_W-1:0] numer;
  logic [PROD_W-1:0]  prod;

  // three column sums, then their total
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sum[c] = '0;
      for (int r = 0; r < 3; r++) begin
        col_sum[c] = col_sum[c] +
                     (ctl.mask[c*3+r] ? SUM_W'(taps[c*3+r]) : '0);
      end
    end
    sum = col_sum[0] + col_sum[1] + col_sum[2];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      sum_q <= sum;
    end
  end

  // (2*sum + count) / (2*count), exact for these ranges
  assign numer = {sum_q, 1'b0} + NUMER_W'(count);
  assign prod  = PROD_W'(numer) * PROD_W'(RECIP[count]);
  assign mean  = prod[RECIP_SHIFT +: 8];
endmodule

// ===== test/box_blur_3x3_edge_aware_checker.sv =====
// Checker for the 3x3 box blur: predicts each blurred item and compares it with the block.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware_checker (
  input  logic        clk,
  input  logic        rst,
  bbe_in_if           pixels,
  bbe_out_if          blurred,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          blur_backlog
);
  import bbe_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } blur_px_t;

  pixel_t      row_above2 [DEF_MAX_WIDTH];
  pixel_t      row_above1 [DEF_MAX_WIDTH];
  pixel_t      win [6];  // left column top/mid/bottom, then centre column
  int unsigned frame_cols;
  int unsigned frame_rows;
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_col;
  int unsigned out_row;
  blur_px_t    blurred_px_q [$];
  blur_px_t    want;
  int          mismatches;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned max_v);
    if (v == 0) return 1;
    return (v > max_v) ? max_v : v;
  endfunction

  task automatic restart_frame();
    win     = '{default: '0};
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  // one accepted item: shift the window, maybe produce one blurred pixel
  task automatic blur_window_step(input op_t op, input pixel_t px_in);
    pixel_t      fresh [3];
    pixel_t      tap;
    int unsigned slot;
    int unsigned cnt;
    int unsigned sum_r, sum_g, sum_b;
    blur_px_t    res;
    logic        last;
    slot     = (in_col < DEF_MAX_WIDTH) ? in_col : DEF_MAX_WIDTH - 1;
    fresh[0] = row_above2[slot];
    fresh[1] = row_above1[slot];
    fresh[2] = (op == OP_PIXEL) ? px_in : '0;
    last     = 1'b0;
    if (in_row > 1 || (in_row == 1 && in_col >= 1)) begin
      cnt   = 0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int dc = 0; dc < 3; dc++) begin
        for (int dr = 0; dr < 3; dr++) begin
          if (!((dc == 0 && out_col == 0) || (dc == 2 && out_col + 1 >= frame_cols) ||
                (dr == 0 && out_row == 0) || (dr == 2 && out_row + 1 >= frame_rows))) begin
            tap = (dc == 2) ? fresh[dr] : win[dc * 3 + dr];
            sum_r += tap[23:16];
            sum_g += tap[15:8];
            sum_b += tap[7:0];
            cnt++;
          end
        end
      end
      if (cnt == 0) cnt = 1;
      last      = (out_row + 1 >= frame_rows) && (out_col + 1 >= frame_cols);
      res.red   = chan_t'((2 * sum_r + cnt) / (2 * cnt));
      res.green = chan_t'((2 * sum_g + cnt) / (2 * cnt));
      res.blue  = chan_t'((2 * sum_b + cnt) / (2 * cnt));
      res.last  = last;
      blurred_px_q.push_back(res);
      out_col++;
      if (out_col >= frame_cols) begin
        out_col = 0;
        out_row++;
      end
    end
    row_above2[slot] = fresh[1];
    row_above1[slot] = fresh[2];
    for (int i = 0; i < 3; i++) begin
      win[i]   = win[i+3];
      win[i+3] = fresh[i];
    end
    in_col++;
    if (in_col >= frame_cols) begin
      in_col = 0;
      in_row++;
    end
    if (last) restart_frame();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (row_above2[i]) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      frame_cols = WIDTH_RESET;
      frame_rows = HEIGHT_RESET;
      restart_frame();
      blurred_px_q.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_WIDTH: begin
            frame_cols = clamp_dim(32'(pwdata[10:0]), DEF_MAX_WIDTH);
          end
          REG_HEIGHT: begin
            frame_rows = clamp_dim(32'(pwdata[12:0]), DEF_MAX_HEIGHT);
          end
        endcase
        restart_frame();
      end
      if (blurred.valid && blurred.ready) begin
        if (blurred_px_q.size() == 0) begin
          $error("blurred item with no prediction waiting");
          mismatches++;
        end else begin
          want = blurred_px_q.pop_front();
          if (blurred.out_red !== want.red) begin
            $error("out_red: expected %0d, actual %0d", want.red, blurred.out_red);
            mismatches++;
          end
          if (blurred.out_green !== want.green) begin
            $error("out_green: expected %0d, actual %0d", want.green, blurred.out_green);
            mismatches++;
          end
          if (blurred.out_blue !== want.blue) begin
            $error("out_blue: expected %0d, actual %0d", want.blue, blurred.out_blue);
            mismatches++;
          end
          if (blurred.frame_last !== want.last) begin
            $error("frame_last: expected %0d, actual %0d", want.last, blurred.frame_last);
            mismatches++;
          end
        end
      end
      if (pixels.valid && pixels.ready) begin
        blur_window_step(op_t'(pixels.operation),
                         {pixels.in_red, pixels.in_green, pixels.in_blue});
      end
    end
    fail_count   <= mismatches;
    blur_backlog <= blurred_px_q.size();
  end

endmodule

// ===== test/box_blur_3x3_edge_aware_tb.sv =====
// Testbench top for the 3x3 box blur: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware_tb;
  import bbe_pkg::*;

  localparam int RANDOM_ITEMS    = 650;
  localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall, well past the pipeline depth
  localparam int SETTLE_CYCLES   = 8;    // result passes the sum and output registers; margin on top
  localparam int CYCLE_LIMIT     = 300000;
  localparam int WIDE_CUT        = 60;   // leading pixels of the widest frame

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  bbe_in_if  pix_if ();
  bbe_out_if blur_if ();

  int          fail_count;
  int          blur_backlog;
  int          tx_idle_pct  = 25;
  int          rx_idle_pct  = 48;
  int          hold_off_req = 0;  // bumped by stimulus, caught up by the receiver
  int          hold_off_ack = 0;
  int          hold_offs    = 0;
  int          items_sent   = 0;
  int          cycle_count  = 0;
  int unsigned frame_w      = 1;  // effective frame size as last programmed
  int unsigned frame_h      = 1;

  // corners, edges and centre of a 3x3 frame; the fifth item goes as a drain tick,
  // so its all-ones data must read as black
  localparam pixel_t CORNER_PX [9] = '{
    24'hFFFFFF, 24'h000000, 24'hFF00FF,
    24'h00FF00, 24'hFFFFFF, 24'hAA55AA,
    24'h55AA55, 24'hFFFFFF, 24'h010101
  };

  box_blur_3x3_edge_aware u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .blurred (blur_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  box_blur_3x3_edge_aware_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pixels       (pix_if),
    .blurred      (blur_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .blur_backlog (blur_backlog)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request so the
  // sum stage and output register fill and pixels.ready drops
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_off_ack) begin
        blur_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_ack = hold_off_req;
      end else begin
        blur_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // two-phase APB write; the register takes the value at the access edge,
  // then the bus is left idle so a following write starts cleanly
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item, with a random gap first, and wait until it is taken
  task automatic push_item(input op_t op, input pixel_t px);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    pix_if.valid     <= 1'b1;
    pix_if.operation <= op;
    pix_if.in_red    <= px[23:16];
    pix_if.in_green  <= px[15:8];
    pix_if.in_blue   <= px[7:0];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // channel value weighted towards the saturating extremes
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame of w x h pixels plus w+1 drain slots; cut > 0 stops early
  task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned cut);
    int unsigned frame_px;
    int unsigned slots;
    op_t         op;
    frame_px = w * h;
    slots    = frame_px + w + 1;
    if (cut != 0 && cut < slots) slots = cut;
    for (int unsigned i = 0; i < slots; i++) begin
      if (i < frame_px) begin
        // the odd drain tick inside the frame stands for a black pixel
        op = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL;
      end else begin
        // pixel data in a drain slot lies outside the frame and is ignored
        op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN;
      end
      push_item(op, {rand_chan(), rand_chan(), rand_chan()});
    end
  endtask

  // sender pause: drop valid, wait for every predicted item, then let the pipe empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (blur_backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          rand_start;
    int          done_rand;
    int          budget_left;
    int          n_noise;
    int          kind;
    int          n_frames;
    int unsigned cut;
    logic        fill_session;

    pix_if.valid     = 1'b0;
    pix_if.operation = OP_PIXEL;
    pix_if.in_red    = '0;
    pix_if.in_green  = '0;
    pix_if.in_blue   = '0;
    blur_if.ready    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed: 3x3 frame covering corner, edge and centre divisors ---
    apb_write(REG_WIDTH, 32'd3);
    apb_write(REG_HEIGHT, 32'd3);
    frame_w = 3;
    frame_h = 3;
    foreach (CORNER_PX[i]) push_item((i == 4) ? OP_DRAIN : OP_PIXEL, CORNER_PX[i]);
    push_item(OP_PIXEL, 24'hFFFFFF);  // first drain slot carries junk pixel data
    repeat (3) push_item(OP_DRAIN, 24'h000000);

    // zero size reads as one: 1x1 frame, lone pixel is its own mean
    settle();
    apb_write(REG_WIDTH, 32'd0);
    apb_write(REG_HEIGHT, 32'd0);
    frame_w = 1;
    frame_h = 1;
    push_item(OP_PIXEL, 24'h807F01);
    repeat (2) push_item(OP_DRAIN, 24'hFFFFFF);

    // --- random sessions: mostly whole frames, some cut short, some noise ---
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      done_rand = items_sent - rand_start;
      if (done_rand >= 500) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (done_rand >= 250) begin
        tx_idle_pct = 48;
        rx_idle_pct = 25;
      end
      settle();

      fill_session = (hold_offs == 0 && done_rand >= 100) || (hold_offs == 1 && done_rand >= 550);
      kind = $urandom_range(0, 7);
      if (fill_session) begin
        // receiver freezes while a full 8x6 frame keeps coming
        hold_off_req++;
        hold_offs++;
        frame_w = 8;
        frame_h = 6;
        apb_write(REG_WIDTH, 32'd8);
        apb_write(REG_HEIGHT, 32'd6);
        kind = 4;
      end else begin
        // kind 1 keeps the width, 2 the height, 3 both (frame carries on mid-way)
        if (kind != 1 && kind != 3) begin
          frame_w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
          apb_write(REG_WIDTH, ($urandom_range(0, 1) != 0) ? ($urandom() & ~32'h7FF) | frame_w
                                                           : frame_w);
        end
        if (kind != 2 && kind != 3) begin
          frame_h = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
          apb_write(REG_HEIGHT, ($urandom_range(0, 1) != 0) ? ($urandom() & ~32'h1FFF) | frame_h
                                                            : frame_h);
        end
      end

      if (kind == 0) begin
        // noise: random kinds and data with no frame in mind
        n_noise     = $urandom_range(5, 40);
        budget_left = RANDOM_ITEMS - (items_sent - rand_start);
        if (n_noise > budget_left) n_noise = budget_left;
        repeat (n_noise) begin
          push_item(op_t'($urandom_range(0, 1)), {rand_chan(), rand_chan(), rand_chan()});
        end
      end else begin
        n_frames = fill_session ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < n_frames; f++) begin
          // ordinary sessions stop at the item budget
          budget_left = RANDOM_ITEMS - (items_sent - rand_start);
          cut = 0;
          if (!fill_session && f == n_frames - 1 && $urandom_range(0, 3) == 0)
            cut = $urandom_range(1, frame_w * frame_h + frame_w);
          if (!fill_session && budget_left > 0 &&
              budget_left < frame_w * frame_h + frame_w + 1 &&
              (cut == 0 || cut > budget_left))
            cut = budget_left;
          if (fill_session || budget_left > 0) send_frame(frame_w, frame_h, cut);
        end
      end
    end

    // --- widest frame, width register saturating to the line store size;
    //     only its first pixels are run, nothing is due inside the lag ---
    settle();
    apb_write(REG_WIDTH, 32'd2047);
    apb_write(REG_HEIGHT, 32'd1);
    send_frame(DEF_MAX_WIDTH, 1, WIDE_CUT);

    // --- tallest frame, height saturating; only its top rows are run ---
    settle();
    apb_write(REG_WIDTH, 32'd1);
    apb_write(REG_HEIGHT, 32'd8191);
    send_frame(1, DEF_MAX_HEIGHT, 40);

    settle();
    if (fail_count == 0 && blur_backlog == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== box_blur_3x3_edge_aware.f =====
hdl/bbe_pkg.sv
hdl/bbe_in_if.sv
hdl/bbe_out_if.sv
hdl/bbe_ram.sv
hdl/bbe_lane.sv
hdl/box_blur_3x3_edge_aware.sv
test/box_blur_3x3_edge_aware_checker.sv
test/box_blur_3x3_edge_aware_tb.sv
